// ----- rtl/lsfe_pkg.sv -----
// Package: shared types and constants for the LCD SPI frame encoder.
`default_nettype none
package lsfe_pkg;

  typedef enum logic [2:0] {
    ACT_CMD    = 3'd0,
    ACT_DATA   = 3'd1,
    ACT_PIX565 = 3'd2,
    ACT_PIX888 = 3'd3,
    ACT_WINDOW = 3'd4,
    ACT_ROTATE = 3'd5
  } action_t;

  localparam int unsigned IDX_W = 6;

  // index of the final byte for each request kind
  localparam logic [IDX_W-1:0] LAST_IDX_BYTE   = 6'd3;
  localparam logic [IDX_W-1:0] LAST_IDX_PIXEL  = 6'd5;
  localparam logic [IDX_W-1:0] LAST_IDX_ROTATE = 6'd7;
  localparam logic [IDX_W-1:0] LAST_IDX_WINDOW = 6'd43;

  localparam logic [7:0] STB_CMD_A  = 8'h11;
  localparam logic [7:0] STB_CMD_B  = 8'h1B;
  localparam logic [7:0] STB_DATA_A = 8'h15;
  localparam logic [7:0] STB_DATA_B = 8'h1F;

  localparam logic [7:0] CMD_COL_ADDR = 8'h2A;
  localparam logic [7:0] CMD_ROW_ADDR = 8'h2B;
  localparam logic [7:0] CMD_MEM_WR   = 8'h2C;
  localparam logic [7:0] CMD_ORIENT   = 8'h36;

  localparam logic [7:0] ORIENT_TBL [4] = '{8'hEA, 8'h4A, 8'h2A, 8'h8A};

  typedef struct packed {
    action_t     action;
    logic [15:0] value;   // byte, 565 word (also reduced 888), or rotation index
    logic [1:0]  extra;   // extra color bits: [1] -> bit 6, [0] -> bit 5
    logic [15:0] xs;
    logic [15:0] xe;
    logic [15:0] ys;
    logic [15:0] ye;
  } item_t;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       end_of_transfer;
    logic       last;
  } beat_t;

endpackage
`default_nettype wire

// ----- rtl/lsfe_if.sv -----
// Interfaces: request channel and serial byte channel.
`default_nettype none
interface lsfe_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [15:0] value;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [15:0] win_x;
  logic [15:0] win_y;
  logic [15:0] win_w;
  logic [15:0] win_h;

  modport source (output valid, action, value, red, green, blue,
                  win_x, win_y, win_w, win_h, input ready);
  modport sink   (input valid, action, value, red, green, blue,
                  win_x, win_y, win_w, win_h, output ready);
endinterface

interface lsfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] spi_byte;
  logic       end_of_transfer;
  logic       last;

  modport source (output valid, spi_byte, end_of_transfer, last, input ready);
  modport sink   (input valid, spi_byte, end_of_transfer, last, output ready);
endinterface
`default_nettype wire

// ----- rtl/lcd_spi_frame_encoder.sv -----
// Top level: LCD SPI frame encoder, one display request in, serial bytes out.
//
//   channel  dir  payload                                               handshake
//   in_ch    in   action, value, red, green, blue, win_x/y/w/h          valid/ready
//   out_ch   out  spi_byte, end_of_transfer, last                       valid/ready
//
// One byte leaves per cycle unless output stalls: command/data 4 bytes, pixel 6,
// rotation 8, window 44, per the byte index counter on the held request; the next
// request is taken in the cycle the prior final byte moves to the output register.
// Actions 6 and 7 are accepted and produce no bytes.
// Reset (synchronous, rst_n low) clears the busy and output valid flags.
// A stalled output holds its beat; the counter waits with it.
`default_nettype none
module lcd_spi_frame_encoder (
  input  logic              clk,
  input  logic              rst_n,
  lsfe_in_if.sink           in_ch,
  lsfe_out_if.source        out_ch
);
  import lsfe_pkg::*;

  item_t            item_r;
  item_t            item_nxt;
  logic             busy_r;
  logic             busy_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  beat_t            out_beat_r;
  beat_t            gen_beat;
  logic             advance;
  logic             accept;
  logic             act_ok;

  lsfe_byte_gen u_byte_gen (
    .item (item_r),
    .idx  (idx_r),
    .beat (gen_beat)
  );

  assign advance     = busy_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !busy_r || (advance && gen_beat.last);
  assign accept      = in_ch.valid && in_ch.ready;
  assign act_ok      = (in_ch.action <= ACT_ROTATE);

  always_comb begin
    item_nxt.action = action_t'(in_ch.action);
    item_nxt.value  = in_ch.value;
    item_nxt.extra  = {in_ch.value[11], in_ch.value[0]};
    if (in_ch.action == ACT_PIX888) begin
      item_nxt.value = {in_ch.red[7:3], in_ch.green[7:2], in_ch.blue[7:3]};
      item_nxt.extra = {in_ch.red[0], in_ch.blue[0]};
    end
    item_nxt.xs = in_ch.win_x;
    item_nxt.xe = in_ch.win_x + in_ch.win_w - 16'd1;
    item_nxt.ys = in_ch.win_y;
    item_nxt.ye = in_ch.win_y + in_ch.win_h - 16'd1;
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (accept) begin
      busy_nxt = act_ok;
      idx_nxt  = '0;
    end else if (advance) begin
      busy_nxt = !gen_beat.last;
      idx_nxt  = idx_r + IDX_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (accept) begin
      item_r <= item_nxt;
    end
    if (advance) begin
      out_beat_r <= gen_beat;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.spi_byte        = out_beat_r.spi_byte;
  assign out_ch.end_of_transfer = out_beat_r.end_of_transfer;
  assign out_ch.last            = out_beat_r.last;

endmodule
`default_nettype wire

// ----- rtl/lsfe_byte_gen.sv -----
// Byte generator: serial byte, transfer end and request end for one item and byte index.
`default_nettype none
module lsfe_byte_gen (
  input  lsfe_pkg::item_t            item,
  input  logic [lsfe_pkg::IDX_W-1:0] idx,
  output lsfe_pkg::beat_t            beat
);
  import lsfe_pkg::*;

  logic [3:0]       send_sel;
  logic [1:0]       sub;
  logic [7:0]       b;
  logic             is_cmd;
  logic [7:0]       hi_b;
  logic [7:0]       lo_b;
  logic [7:0]       stb_a;
  logic [7:0]       stb_b;
  logic [7:0]       ext_b;
  logic [IDX_W-1:0] last_idx;
  logic             is_pixel;

  assign send_sel = idx[5:2];
  assign sub      = idx[1:0];
  assign is_pixel = (item.action == ACT_PIX565) || (item.action == ACT_PIX888);

  always_comb begin
    b      = item.value[7:0];
    is_cmd = 1'b0;
    unique case (item.action)
      ACT_CMD: begin
        b      = item.value[7:0];
        is_cmd = 1'b1;
      end
      ACT_WINDOW: begin
        unique case (send_sel)
          4'd0:    begin b = CMD_COL_ADDR; is_cmd = 1'b1; end
          4'd1:    b = item.xs[15:8];
          4'd2:    b = item.xs[7:0];
          4'd3:    b = item.xe[15:8];
          4'd4:    b = item.xe[7:0];
          4'd5:    begin b = CMD_ROW_ADDR; is_cmd = 1'b1; end
          4'd6:    b = item.ys[15:8];
          4'd7:    b = item.ys[7:0];
          4'd8:    b = item.ye[15:8];
          4'd9:    b = item.ye[7:0];
          default: begin b = CMD_MEM_WR; is_cmd = 1'b1; end
        endcase
      end
      ACT_ROTATE: begin
        if (send_sel == 4'd0) begin
          b      = CMD_ORIENT;
          is_cmd = 1'b1;
        end else begin
          b = ORIENT_TBL[item.value[1:0]];
        end
      end
      default: begin
        b      = item.value[7:0];
        is_cmd = 1'b0;
      end
    endcase
  end

  assign hi_b  = {1'b0, b[7:1]};
  assign lo_b  = {2'b00, b[0], 5'b00000};
  assign stb_a = is_cmd ? STB_CMD_A : STB_DATA_A;
  assign stb_b = is_cmd ? STB_CMD_B : STB_DATA_B;
  assign ext_b = {1'b0, item.extra, 5'b00000};

  always_comb begin
    unique case (item.action)
      ACT_PIX565, ACT_PIX888: last_idx = LAST_IDX_PIXEL;
      ACT_WINDOW:             last_idx = LAST_IDX_WINDOW;
      ACT_ROTATE:             last_idx = LAST_IDX_ROTATE;
      default:                last_idx = LAST_IDX_BYTE;
    endcase
  end

  always_comb begin
    beat.last = (idx == last_idx);
    if (is_pixel) begin
      unique case (idx[2:0])
        3'd0:    begin beat.spi_byte = item.value[15:8];    beat.end_of_transfer = 1'b0; end
        3'd1:    begin beat.spi_byte = item.value[7:0];     beat.end_of_transfer = 1'b0; end
        3'd2:    begin beat.spi_byte = ext_b | STB_DATA_A;  beat.end_of_transfer = 1'b1; end
        3'd3:    begin beat.spi_byte = item.value[15:8];    beat.end_of_transfer = 1'b0; end
        3'd4:    begin beat.spi_byte = item.value[7:0];     beat.end_of_transfer = 1'b0; end
        default: begin beat.spi_byte = ext_b | STB_DATA_B;  beat.end_of_transfer = 1'b1; end
      endcase
    end else begin
      unique case (sub)
        2'd0:    begin beat.spi_byte = hi_b;          beat.end_of_transfer = 1'b0; end
        2'd1:    begin beat.spi_byte = lo_b | stb_a;  beat.end_of_transfer = 1'b1; end
        2'd2:    begin beat.spi_byte = hi_b;          beat.end_of_transfer = 1'b0; end
        default: begin beat.spi_byte = lo_b | stb_b;  beat.end_of_transfer = 1'b1; end
      endcase
    end
  end

endmodule
`default_nettype wire
